// ----- rtl/polygon_face_normal_top_assert.svh -----
// assertion macros for the polygon face normal rtl, included by pfn_back
// expects signals clk and arst_n in the scope that uses them
`ifndef POLYGON_FACE_NORMAL_TOP_ASSERT_SVH
`define POLYGON_FACE_NORMAL_TOP_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define PFN_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define PFN_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/pfn_pkg.sv -----
// shared constants, types and state encodings of the polygon face normal block
// no dependencies
package pfn_pkg;

	localparam int MAX_VERTICES = 256;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 2);
	localparam int CRD_W        = 24;
	localparam int SUM_W        = 58;
	localparam int MAG_W        = SUM_W - 1;
	localparam int NRM_W        = 32;
	localparam int ML_W         = 31;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic signed [NRM_W-1:0] Q30_ONE = 32'sh4000_0000;

	typedef enum logic [1:0] {
		F_IDLE,
		F_EDGE,
		F_CLOSE,
		F_PUSH
	} pfn_front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_THR,
		B_SCALE,
		B_SQ,
		B_SQRT,
		B_DIV,
		B_OUT
	} pfn_back_state_t;

	// accumulated face handed from front to back
	typedef struct packed {
		logic signed [SUM_W-1:0] sum_x;
		logic signed [SUM_W-1:0] sum_y;
		logic signed [SUM_W-1:0] sum_z;
		logic                    over;
	} pfn_face_t;

	typedef struct packed {
		logic full;
		logic empty;
	} pfn_q_stat_t;

endpackage

// ----- rtl/pfn_if.sv -----
// channel interfaces: vertex input, normal output, min_length write
// depends on pfn_pkg
interface pfn_vertex_if import pfn_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [CRD_W-1:0] vertex_x;
	logic signed [CRD_W-1:0] vertex_y;
	logic signed [CRD_W-1:0] vertex_z;
	logic                    last_vertex;

	modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
	modport sink (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface pfn_normal_if import pfn_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [NRM_W-1:0] normal_x;
	logic signed [NRM_W-1:0] normal_y;
	logic signed [NRM_W-1:0] normal_z;
	logic                    normalized;
	logic                    too_many_vertices;

	modport source (output valid, normal_x, normal_y, normal_z, normalized,
		too_many_vertices, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, normalized,
		too_many_vertices, output ready);
endinterface

interface pfn_cfg_if import pfn_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ML_W-1:0] min_length;

	modport source (output valid, min_length, input ready);
	modport sink (input valid, min_length, output ready);
endinterface

// ----- rtl/pfn_front.sv -----
// front end: takes vertices and accumulates newell cross terms with one multiplier
// depends on pfn_pkg and pfn_vertex_if
module pfn_front import pfn_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	pfn_vertex_if.sink    vtx,
	output logic          push,
	output pfn_face_t     push_data,
	input  pfn_q_stat_t   q_stat
);

	pfn_front_state_t state_q, state_d;
	logic signed [CRD_W-1:0] first_q [3];
	logic signed [CRD_W-1:0] prev_q  [3];
	logic signed [CRD_W-1:0] cur_q   [3];
	logic                    last_q;
	logic [CNT_W-1:0]        count_q;
	logic [1:0]              step_q;
	logic [1:0]              acc_idx;
	logic signed [49:0]      prod_q;
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [CRD_W-1:0] op_a [3];
	logic signed [CRD_W-1:0] op_b [3];
	logic signed [CRD_W-1:0] vin  [3];
	logic signed [49:0]      term;
	logic                    accept;

	function automatic logic signed [49:0] newell_term(
		input logic signed [CRD_W-1:0] a1, b1, a2, b2);
		logic signed [CRD_W:0] d;
		logic signed [CRD_W:0] s;
		d = $signed({a1[CRD_W-1], a1}) - $signed({b1[CRD_W-1], b1});
		s = $signed({a2[CRD_W-1], a2}) + $signed({b2[CRD_W-1], b2});
		return d * s;
	endfunction

	assign accept  = vtx.valid && vtx.ready;
	assign vin[0]  = vtx.vertex_x;
	assign vin[1]  = vtx.vertex_y;
	assign vin[2]  = vtx.vertex_z;
	assign acc_idx = step_q - 2'd1;

	// closing edge runs back to the first vertex
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			op_a[i] = prev_q[i];
			op_b[i] = (state_q == F_CLOSE) ? first_q[i] : cur_q[i];
		end
		case (step_q)
			2'd0:    term = newell_term(op_a[1], op_b[1], op_a[2], op_b[2]);
			2'd1:    term = newell_term(op_a[2], op_b[2], op_a[0], op_b[0]);
			2'd2:    term = newell_term(op_a[0], op_b[0], op_a[1], op_b[1]);
			default: term = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (count_q == '0)
						state_d = vtx.last_vertex ? F_PUSH : F_IDLE;
					else if (count_q < CNT_W'(MAX_VERTICES))
						state_d = F_EDGE;
					else
						state_d = vtx.last_vertex ? F_CLOSE : F_IDLE;
				end
			end
			F_EDGE: begin
				if (step_q == 2'd3)
					state_d = last_q ? F_CLOSE : F_IDLE;
			end
			F_CLOSE: begin
				if (step_q == 2'd3)
					state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_stat.full)
					state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		vtx.ready       = (state_q == F_IDLE);
		push            = (state_q == F_PUSH) && !q_stat.full;
		push_data.sum_x = sum_q[0];
		push_data.sum_y = sum_q[1];
		push_data.sum_z = sum_q[2];
		push_data.over  = (count_q > CNT_W'(MAX_VERTICES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			count_q <= '0;
			step_q  <= '0;
			for (int i = 0; i < 3; i++)
				sum_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q <= vtx.last_vertex;
				step_q <= '0;
				for (int i = 0; i < 3; i++)
					cur_q[i] <= vin[i];
				if (count_q == '0) begin
					for (int i = 0; i < 3; i++) begin
						first_q[i] <= vin[i];
						prev_q[i]  <= vin[i];
					end
					count_q <= CNT_W'(1);
				end else if (count_q < CNT_W'(MAX_VERTICES)) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					count_q <= CNT_W'(MAX_VERTICES + 1);
				end
			end
			if (state_q == F_EDGE || state_q == F_CLOSE) begin
				step_q <= step_q + 2'd1;
				if (step_q != 2'd3)
					prod_q <= term;
				if (step_q != 2'd0)
					sum_q[acc_idx] <= sum_q[acc_idx] + SUM_W'(prod_q);
				if (state_q == F_EDGE && step_q == 2'd3) begin
					for (int i = 0; i < 3; i++)
						prev_q[i] <= cur_q[i];
				end
			end
			if (push) begin
				count_q <= '0;
				for (int i = 0; i < 3; i++)
					sum_q[i] <= '0;
			end
		end
	end

endmodule

// ----- rtl/pfn_queue.sv -----
// short face queue between front and back
// depends on pfn_pkg
module pfn_queue import pfn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  pfn_face_t   push_data,
	input  logic        pop,
	output pfn_face_t   pop_data,
	output pfn_q_stat_t q_stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

	pfn_face_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [QC_W-1:0]  fill_q;

	assign pop_data     = mem_q[rd_ptr_q];
	assign q_stat.full  = (fill_q == QC_W'(QUEUE_DEPTH));
	assign q_stat.empty = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				fill_q <= fill_q + QC_W'(1);
			else if (pop && !push)
				fill_q <= fill_q - QC_W'(1);
		end
	end

endmodule

// ----- rtl/pfn_back.sv -----
// back end: threshold test, scaling, squared length, square root and three divisions for a normalized face
// depends on pfn_pkg, pfn_normal_if and the assertion header
`include "polygon_face_normal_top_assert.svh"

module pfn_back import pfn_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [ML_W-1:0] min_length,
	input  pfn_face_t       face,
	input  pfn_q_stat_t     q_stat,
	output logic            pop,
	pfn_normal_if.source    nrm
);

	pfn_back_state_t state_q, state_d;
	logic [MAG_W-1:0]        mag_q [3];
	logic                    neg_q [3];
	logic [MAG_W-1:0]        maxmag_q;
	logic                    over_q;
	logic                    normed_q;
	logic [5:0]              cnt_q;
	logic [1:0]              idx_q;
	logic [63:0]             prod_q;
	logic [63:0]             acc_q;
	logic [63:0]             rad_q;
	logic [63:0]             root_q;
	logic [63:0]             bit_q;
	logic [31:0]             len_q;
	logic [32:0]             rem_q;
	logic [30:0]             dsh_q;
	logic [30:0]             quo_q;
	logic signed [NRM_W-1:0] res_q [3];
	logic signed [NRM_W-1:0] out_x_q, out_y_q, out_z_q;
	logic                    out_norm_q, out_over_q, out_valid_q;

	logic signed [SUM_W-1:0] fsum [3];
	logic [MAG_W-1:0]        fmag [3];
	logic [MAG_W-1:0]        fmax;
	logic [31:0]             sq_op;
	logic [63:0]             sq_prod;
	logic [63:0]             root_try;
	logic                    root_ge;
	logic [32:0]             rem_sh;
	logic                    rem_ge;
	logic [30:0]             quo_next;
	logic                    out_load;

	assign fsum[0] = face.sum_x;
	assign fsum[1] = face.sum_y;
	assign fsum[2] = face.sum_z;

	always_comb begin
		fmax = '0;
		for (int i = 0; i < 3; i++) begin
			fmag[i] = fsum[i][SUM_W-1] ? MAG_W'(-fsum[i]) : MAG_W'(fsum[i]);
			if (fmag[i] > fmax)
				fmax = fmag[i];
		end
	end

	// one shared squaring multiplier
	always_comb begin
		if (state_q == B_THR && cnt_q == 6'd3)
			sq_op = {1'b0, min_length};
		else if (cnt_q < 6'd3)
			sq_op = mag_q[cnt_q[1:0]][31:0];
		else
			sq_op = '0;
	end
	assign sq_prod = sq_op * sq_op;

	assign root_try = root_q + bit_q;
	assign root_ge  = (rad_q >= root_try);
	assign rem_sh   = {rem_q[31:0], dsh_q[30]};
	assign rem_ge   = (rem_sh >= {1'b0, len_q});
	assign quo_next = {quo_q[29:0], rem_ge};

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_stat.empty)
					state_d = (fmax[MAG_W-1:31] != '0) ? B_SCALE : B_THR;
			end
			B_THR: begin
				if (cnt_q == 6'd4)
					state_d = (acc_q > prod_q) ? B_SCALE : B_OUT;
			end
			B_SCALE: begin
				if (maxmag_q[MAG_W-1:31] == '0 && maxmag_q[30])
					state_d = B_SQ;
			end
			B_SQ: begin
				if (cnt_q == 6'd3)
					state_d = B_SQRT;
			end
			B_SQRT: begin
				if (cnt_q == 6'd31)
					state_d = B_DIV;
			end
			B_DIV: begin
				if (cnt_q == 6'd30 && idx_q == 2'd2)
					state_d = B_OUT;
			end
			B_OUT: begin
				if (out_load)
					state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop                   = (state_q == B_IDLE) && !q_stat.empty;
		out_load              = (state_q == B_OUT) && (!out_valid_q || nrm.ready);
		nrm.valid             = out_valid_q;
		nrm.normal_x          = out_x_q;
		nrm.normal_y          = out_y_q;
		nrm.normal_z          = out_z_q;
		nrm.normalized        = out_norm_q;
		nrm.too_many_vertices = out_over_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (nrm.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				B_IDLE: begin
					cnt_q <= '0;
					if (pop) begin
						for (int i = 0; i < 3; i++) begin
							mag_q[i] <= fmag[i];
							neg_q[i] <= fsum[i][SUM_W-1];
						end
						maxmag_q <= fmax;
						over_q   <= face.over;
						normed_q <= 1'b1;
					end
				end
				B_THR: begin
					prod_q <= sq_prod;
					acc_q  <= (cnt_q == 6'd0) ? '0 : acc_q + prod_q;
					if (cnt_q == 6'd4) begin
						cnt_q    <= '0;
						normed_q <= (acc_q > prod_q);
						// raw sums clamped to plus or minus one in q1.30
						for (int i = 0; i < 3; i++) begin
							if (mag_q[i] > MAG_W'(Q30_ONE))
								res_q[i] <= neg_q[i] ? -Q30_ONE : Q30_ONE;
							else
								res_q[i] <= neg_q[i] ? -$signed(mag_q[i][31:0])
									: $signed(mag_q[i][31:0]);
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				B_SCALE: begin
					cnt_q <= '0;
					if (maxmag_q[MAG_W-1:31] != '0) begin
						maxmag_q <= maxmag_q >> 1;
						for (int i = 0; i < 3; i++)
							mag_q[i] <= mag_q[i] >> 1;
					end else if (!maxmag_q[30]) begin
						maxmag_q <= maxmag_q << 1;
						for (int i = 0; i < 3; i++)
							mag_q[i] <= mag_q[i] << 1;
					end
				end
				B_SQ: begin
					prod_q <= sq_prod;
					acc_q  <= (cnt_q == 6'd0) ? '0 : acc_q + prod_q;
					if (cnt_q == 6'd3) begin
						cnt_q  <= '0;
						rad_q  <= acc_q + prod_q;
						root_q <= '0;
						bit_q  <= 64'h4000_0000_0000_0000;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				B_SQRT: begin
					bit_q <= bit_q >> 2;
					if (root_ge) begin
						rad_q  <= rad_q - root_try;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					if (cnt_q == 6'd31) begin
						cnt_q <= '0;
						idx_q <= '0;
						len_q <= root_ge ? 32'((root_q >> 1) + bit_q) : 32'(root_q >> 1);
						rem_q <= {3'b000, mag_q[0][30:1]};
						dsh_q <= {mag_q[0][0], 30'b0};
						quo_q <= '0;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				B_DIV: begin
					if (cnt_q == 6'd30) begin
						cnt_q <= '0;
						res_q[idx_q] <= neg_q[idx_q] ? -$signed({1'b0, quo_next})
							: $signed({1'b0, quo_next});
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
					if (cnt_q == 6'd30 && idx_q != 2'd2) begin
						idx_q <= idx_q + 2'd1;
						rem_q <= {3'b000, mag_q[idx_q + 2'd1][30:1]};
						dsh_q <= {mag_q[idx_q + 2'd1][0], 30'b0};
						quo_q <= '0;
					end else begin
						rem_q <= rem_ge ? rem_sh - {1'b0, len_q} : rem_sh;
						dsh_q <= dsh_q << 1;
						quo_q <= quo_next;
					end
				end
				B_OUT: begin
					cnt_q <= '0;
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q    <= res_q[0];
			out_y_q    <= res_q[1];
			out_z_q    <= res_q[2];
			out_norm_q <= normed_q;
			out_over_q <= over_q;
		end
	end

	`PFN_ASSERT_CLK(a_div_len_unit, (state_q == B_DIV) |-> (len_q[31:30] != 2'b00), "divisor below unit length")
	`PFN_ASSERT_CLK(a_norm_bound, (out_valid_q && out_norm_q) |-> (out_x_q <= Q30_ONE && out_x_q >= -Q30_ONE), "normalized x out of range")
	`PFN_ASSERT_CLK(a_out_loaded, (state_q == B_OUT && state_d == B_IDLE) |=> out_valid_q, "result lost on output load")
	`PFN_ASSERT_NEVER(a_scale_zero, (state_q == B_SCALE) && (maxmag_q == '0), "scaling a zero vector")

endmodule

// ----- rtl/polygon_face_normal_top.sv -----
// Newell polygon normal: vertices in on vtx, one normal per polygon out on nrm.
// The min_length threshold is written over cfg (always ready, reset value 17).
// A polygon is a run of vertex items ending in one with last_vertex set.
// Front end: one multiplier; each accepted vertex after the first, up to the
// vertex bound, runs the edge steps; the last vertex adds steps for the closing
// edge and a push state that hands the face to a two entry queue.
// Back end per face: pop, threshold test (skipped when a sum is 2^31 or more),
// one bit scaling, squared length, square root loop, three shift-subtract
// divisions and the output load; a face under the threshold goes from the test
// straight to the output load with the raw clamped sum instead.
// Vertices keep flowing into the front end while the back end works on earlier
// faces, until the queue is full.
// From the last vertex the result passes the front end, queue and back end and
// is registered in the output register before it shows on nrm.
// When nrm stalls, the result holds in the output register, the back end waits,
// then the queue fills and finally vtx.ready drops.
// Reset clears the accumulators, vertex count, queue and output valid and sets
// min_length to 17.
module polygon_face_normal_top import pfn_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	pfn_vertex_if.sink    vtx,
	pfn_normal_if.source  nrm,
	pfn_cfg_if.sink       cfg
);

	logic [ML_W-1:0] min_length_q;
	logic            push;
	logic            pop;
	pfn_face_t       push_data;
	pfn_face_t       pop_data;
	pfn_q_stat_t     q_stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= ML_W'(17);
		end else if (cfg.valid && cfg.ready) begin
			min_length_q <= cfg.min_length;
		end
	end

	pfn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx       (vtx),
		.push      (push),
		.push_data (push_data),
		.q_stat    (q_stat)
	);

	pfn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	pfn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.min_length (min_length_q),
		.face       (pop_data),
		.q_stat     (q_stat),
		.pop        (pop),
		.nrm        (nrm)
	);

endmodule

// ----- tb/sv/polygon_face_normal_top_tb.sv -----
// testbench for polygon_face_normal_top: random and directed polygons with a Newell predictor
// depends on pfn_pkg, the channel interfaces in pfn_if.sv and the rtl top level
module polygon_face_normal_top_tb;
	import pfn_pkg::*;

	typedef struct {
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] z;
		logic                    last;
	} vertex_t;

	typedef struct {
		logic signed [NRM_W-1:0] x;
		logic signed [NRM_W-1:0] y;
		logic signed [NRM_W-1:0] z;
		logic                    normed;
		logic                    over;
	} face_normal_t;

	logic clk;
	logic arst_n;

	pfn_vertex_if vtx ();
	pfn_normal_if nrm ();
	pfn_cfg_if    cfg ();

	polygon_face_normal_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.vtx(vtx),
		.nrm(nrm),
		.cfg(cfg)
	);

	vertex_t      vertex_q[$];
	face_normal_t normal_q[$];
	vertex_t      cur_vertex;
	int           errors = 0;
	int           send_idle = 0;
	int           recv_idle = 0;

	// predictor state
	logic [ML_W-1:0] thr_len;
	longint          first_v[3];
	longint          prev_v[3];
	longint          newell_sum[3];
	int              vcount;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic void add_edge(longint a[3], longint b[3]);
		newell_sum[0] += (a[1] - b[1]) * (a[2] + b[2]);
		newell_sum[1] += (a[2] - b[2]) * (a[0] + b[0]);
		newell_sum[2] += (a[0] - b[0]) * (a[1] + b[1]);
	endfunction

	// returns 1 when the vertex closes a polygon, with the face normal in fn
	function automatic bit face_normal_step(vertex_t v, output face_normal_t fn);
		longint          c[3];
		longint unsigned mag[3];
		longint unsigned maxmag;
		longint unsigned sc[3];
		longint unsigned len;
		longint unsigned sq;
		longint          q;
		bit              normed;
		int              msb;
		c[0] = v.x;
		c[1] = v.y;
		c[2] = v.z;
		if (vcount == 0) begin
			first_v = c;
			prev_v = c;
			vcount = 1;
		end else if (vcount < MAX_VERTICES) begin
			add_edge(prev_v, c);
			prev_v = c;
			vcount++;
		end else begin
			vcount = MAX_VERTICES + 1;
		end
		if (!v.last)
			return 0;
		add_edge(prev_v, first_v);
		fn.over = vcount > MAX_VERTICES;
		maxmag = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = newell_sum[i] < 0 ? -newell_sum[i] : newell_sum[i];
			if (mag[i] > maxmag)
				maxmag = mag[i];
		end
		if (maxmag >= (64'd1 << 31)) begin
			normed = 1;
		end else begin
			sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
			normed = sq > longint'(thr_len) * longint'(thr_len);
		end
		if (normed) begin
			msb = 63;
			while (msb > 0 && !maxmag[msb])
				msb--;
			for (int i = 0; i < 3; i++)
				sc[i] = msb < 30 ? mag[i] << (30 - msb) : mag[i] >> (msb - 30);
			len = int_sqrt(sc[0] * sc[0] + sc[1] * sc[1] + sc[2] * sc[2]);
			for (int i = 0; i < 3; i++) begin
				q = (sc[i] << 30) / len;
				c[i] = newell_sum[i] < 0 ? -q : q;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				c[i] = newell_sum[i];
				if (c[i] > longint'(Q30_ONE))
					c[i] = Q30_ONE;
				if (c[i] < -longint'(Q30_ONE))
					c[i] = -longint'(Q30_ONE);
			end
		end
		fn.x = c[0][NRM_W-1:0];
		fn.y = c[1][NRM_W-1:0];
		fn.z = c[2][NRM_W-1:0];
		fn.normed = normed;
		for (int i = 0; i < 3; i++) begin
			first_v[i] = 0;
			prev_v[i] = 0;
			newell_sum[i] = 0;
		end
		vcount = 0;
		return 1;
	endfunction

	function automatic void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// vertex driver
	always @(posedge clk) begin
		face_normal_t fn;
		if (arst_n) begin
			if (vtx.valid && vtx.ready) begin
				if (face_normal_step(cur_vertex, fn))
					normal_q = {normal_q, fn};
			end
			if (!vtx.valid || vtx.ready) begin
				if (vertex_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					cur_vertex = vertex_q.pop_front();
					vtx.valid <= 1'b1;
					vtx.vertex_x <= cur_vertex.x;
					vtx.vertex_y <= cur_vertex.y;
					vtx.vertex_z <= cur_vertex.z;
					vtx.last_vertex <= cur_vertex.last;
				end else begin
					vtx.valid <= 1'b0;
				end
			end
		end
	end

	// normal monitor
	always @(posedge clk) begin
		face_normal_t fn;
		if (arst_n) begin
			if (nrm.valid && nrm.ready) begin
				if (normal_q.size() == 0) begin
					$display("%0t: unexpected normal item, expected none, actual %0d %0d %0d",
						$time, nrm.normal_x, nrm.normal_y, nrm.normal_z);
					errors++;
				end else begin
					fn = normal_q.pop_front();
					check_field("normal_x", fn.x, nrm.normal_x);
					check_field("normal_y", fn.y, nrm.normal_y);
					check_field("normal_z", fn.z, nrm.normal_z);
					check_field("normalized", fn.normed, nrm.normalized);
					check_field("too_many_vertices", fn.over, nrm.too_many_vertices);
				end
			end
			nrm.ready <= $urandom_range(99) >= recv_idle;
		end
	end

	task automatic push_vertex(int x, int y, int z, bit last);
		vertex_t v;
		v.x = CRD_W'(x);
		v.y = CRD_W'(y);
		v.z = CRD_W'(z);
		v.last = last;
		vertex_q = {vertex_q, v};
	endtask

	function automatic int rand_coord();
		logic signed [CRD_W-1:0] c;
		c = CRD_W'($urandom);
		return c >>> $urandom_range(0, 22);
	endfunction

	task automatic push_polygon(int n);
		for (int i = 0; i < n; i++)
			push_vertex(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
	endtask

	task automatic write_min_length(logic [ML_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.min_length <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		thr_len = val;
	endtask

	task automatic drain();
		do @(negedge clk); while (vertex_q.size() != 0 || vtx.valid || normal_q.size() != 0);
		// a non-final vertex may still be in the front end
		repeat (250) @(negedge clk);
	endtask

	task automatic random_phase(int n_vertices);
		int sent;
		int n;
		sent = 0;
		while (sent < n_vertices) begin
			n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 12) : $urandom_range(3, 6);
			push_polygon(n);
			sent += n;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		vtx.valid = 1'b0;
		vtx.vertex_x = '0;
		vtx.vertex_y = '0;
		vtx.vertex_z = '0;
		vtx.last_vertex = 1'b0;
		nrm.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.min_length = '0;
		thr_len = 17;
		vcount = 0;
		for (int i = 0; i < 3; i++) begin
			first_v[i] = 0;
			prev_v[i] = 0;
			newell_sum[i] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset threshold first, no write yet
		send_idle = 11;
		recv_idle = 46;
		push_vertex(8388607, -8388608, 8388607, 1);
		push_vertex(8388607, 8388607, 8388607, 0);
		push_vertex(-8388608, 8388607, -8388608, 0);
		push_vertex(8388607, -8388608, -8388608, 1);
		// collinear, zero length
		push_vertex(0, 0, 0, 0);
		push_vertex(4096, 4096, 4096, 0);
		push_vertex(8192, 8192, 8192, 1);
		// tiny triangle under the threshold
		push_vertex(0, 0, 0, 0);
		push_vertex(1, 0, 0, 0);
		push_vertex(0, 1, 0, 1);
		// small triangle above it
		push_vertex(0, 0, 0, 0);
		push_vertex(8, 0, 0, 0);
		push_vertex(0, 8, 0, 1);
		// square of extreme values
		push_vertex(-8388608, -8388608, 0, 0);
		push_vertex(8388607, -8388608, 0, 0);
		push_vertex(8388607, 8388607, 0, 0);
		push_vertex(-8388608, 8388607, 0, 1);
		push_vertex(-1, -1, -1, 1);
		drain();

		write_min_length(0);
		push_vertex(0, 0, 0, 0);
		push_vertex(1, 0, 0, 0);
		push_vertex(0, 1, 0, 1);
		// polygon past the vertex bound
		push_polygon(MAX_VERTICES + 3);
		random_phase(80);
		drain();

		write_min_length({ML_W{1'b1}});
		send_idle = 46;
		recv_idle = 11;
		push_vertex(8388607, -8388608, 8388607, 0);
		push_vertex(-8388608, 8388607, 8388607, 0);
		push_vertex(8388607, 8388607, -8388608, 1);
		random_phase(80);
		drain();

		write_min_length(ML_W'($urandom_range(0, 1 << 20)));
		push_polygon(MAX_VERTICES);
		random_phase(40);
		drain();

		send_idle = 0;
		recv_idle = 0;
		write_min_length(17);
		push_polygon(MAX_VERTICES + 1);
		random_phase(40);
		drain();

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pfn_pkg.sv
rtl/pfn_if.sv
rtl/pfn_front.sv
rtl/pfn_queue.sv
rtl/pfn_back.sv
rtl/polygon_face_normal_top.sv
tb/sv/polygon_face_normal_top_tb.sv
